[hw/rtl/wmlb_pkg.sv]
// Shared types and constants for the weighted material layer blend block.
package wmlb_pkg;

  // Layers folded into one texel; the sum widths below are sized for this count.
  localparam int unsigned MaxLayers = 4;

  localparam int unsigned SumW  = 18;
  localparam int unsigned NSumW = 19;
  localparam int unsigned WTotW = 10;

  // Accumulated texel handed from the front end to the back end.
  typedef struct packed {
    logic [SumW-1:0]         alb_r;
    logic [SumW-1:0]         alb_g;
    logic [SumW-1:0]         alb_b;
    logic signed [NSumW-1:0] nrm_x;
    logic signed [NSumW-1:0] nrm_y;
    logic signed [NSumW-1:0] nrm_z;
    logic [SumW-1:0]         mat_o;
    logic [SumW-1:0]         mat_r;
    logic [SumW-1:0]         mat_m;
    logic [WTotW-1:0]        wtot;
  } texel_sums_t;

  typedef struct packed {
    logic [7:0] alb_r;
    logic [7:0] alb_g;
    logic [7:0] alb_b;
    logic [7:0] nrm_x;
    logic [7:0] nrm_y;
    logic [7:0] nrm_z;
    logic [7:0] occ;
    logic [7:0] rgh;
    logic [7:0] met;
  } texel_out_t;

endpackage

[hw/rtl/weighted_material_layer_blend.sv]
// Top level of the weighted material layer blend block.
// A texel is offered once the idle back end has popped its sums and run the divide steps,
// the three squares and the square-root steps, then per axis the normalize steps and one
// encode step; when the normal sum is zero the first axis skips its normalize steps.
// Throughput: one layer request per cycle until the two-entry queue fills; the back end
// handles one texel at a time. Reset clears the accumulated sums and the queue and idles the back end.
module weighted_material_layer_blend import wmlb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] weight_i,
  input  logic [7:0] albedo_r_i,
  input  logic [7:0] albedo_g_i,
  input  logic [7:0] albedo_b_i,
  input  logic [7:0] normal_in_x_i,
  input  logic [7:0] normal_in_y_i,
  input  logic [7:0] normal_in_z_i,
  input  logic [7:0] occlusion_in_i,
  input  logic [7:0] roughness_in_i,
  input  logic [7:0] metallic_in_i,
  input  logic       last_layer_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] albedo_r_out_o,
  output logic [7:0] albedo_g_out_o,
  output logic [7:0] albedo_b_out_o,
  output logic [7:0] normal_x_out_o,
  output logic [7:0] normal_y_out_o,
  output logic [7:0] normal_z_out_o,
  output logic [7:0] occlusion_out_o,
  output logic [7:0] roughness_out_o,
  output logic [7:0] metallic_out_o
);

  texel_sums_t push_data, q_data;
  texel_out_t  tex;
  logic        push, full, q_valid, pop;

  wmlb_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .weight_i, .alb_r_i(albedo_r_i), .alb_g_i(albedo_g_i), .alb_b_i(albedo_b_i),
    .nrm_x_i(normal_in_x_i), .nrm_y_i(normal_in_y_i), .nrm_z_i(normal_in_z_i),
    .occ_i(occlusion_in_i), .rgh_i(roughness_in_i), .met_i(metallic_in_i),
    .last_i(last_layer_i), .push_o(push), .sums_o(push_data), .full_i(full)
  );

  wmlb_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(full),
    .valid_o(q_valid), .pop_i(pop), .data_o(q_data)
  );

  wmlb_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .pop_o(pop), .sums_i(q_data),
    .valid_o, .ready_i, .texel_o(tex)
  );

  assign albedo_r_out_o  = tex.alb_r;
  assign albedo_g_out_o  = tex.alb_g;
  assign albedo_b_out_o  = tex.alb_b;
  assign normal_x_out_o  = tex.nrm_x;
  assign normal_y_out_o  = tex.nrm_y;
  assign normal_z_out_o  = tex.nrm_z;
  assign occlusion_out_o = tex.occ;
  assign roughness_out_o = tex.rgh;
  assign metallic_out_o  = tex.met;

endmodule

[hw/rtl/wmlb_front.sv]
// Front end: accumulates weighted layer contributions into texel sums.
module wmlb_front import wmlb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  weight_i,
  input  logic [7:0]  alb_r_i,
  input  logic [7:0]  alb_g_i,
  input  logic [7:0]  alb_b_i,
  input  logic [7:0]  nrm_x_i,
  input  logic [7:0]  nrm_y_i,
  input  logic [7:0]  nrm_z_i,
  input  logic [7:0]  occ_i,
  input  logic [7:0]  rgh_i,
  input  logic [7:0]  met_i,
  input  logic        last_i,
  output logic        push_o,
  output texel_sums_t sums_o,
  input  logic        full_i
);

  localparam int unsigned CntW = $clog2(MaxLayers + 1);

  texel_sums_t     acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            add;
  logic            fire;

  assign ready_o = !full_i;
  assign fire    = valid_i && ready_o;
  assign add     = (cnt_q < CntW'(MaxLayers)) && (weight_i != 8'd0);

  function automatic logic signed [NSumW-1:0] nterm(input logic [7:0] b,
                                                    input logic [7:0] w);
    logic signed [9:0] s;
    begin
      s = $signed({1'b0, b, 1'b0}) - 10'sd255;
      nterm = NSumW'(s * $signed({1'b0, w}));
    end
  endfunction

  always_comb begin
    acc_d = acc_q;
    if (add) begin
      acc_d.alb_r = acc_q.alb_r + SumW'(alb_r_i * weight_i);
      acc_d.alb_g = acc_q.alb_g + SumW'(alb_g_i * weight_i);
      acc_d.alb_b = acc_q.alb_b + SumW'(alb_b_i * weight_i);
      acc_d.mat_o = acc_q.mat_o + SumW'(occ_i * weight_i);
      acc_d.mat_r = acc_q.mat_r + SumW'(rgh_i * weight_i);
      acc_d.mat_m = acc_q.mat_m + SumW'(met_i * weight_i);
      acc_d.nrm_x = acc_q.nrm_x + nterm(nrm_x_i, weight_i);
      acc_d.nrm_y = acc_q.nrm_y + nterm(nrm_y_i, weight_i);
      acc_d.nrm_z = acc_q.nrm_z + nterm(nrm_z_i, weight_i);
      acc_d.wtot  = acc_q.wtot + WTotW'(weight_i);
    end
    cnt_d = (cnt_q < CntW'(MaxLayers)) ? cnt_q + 1'b1 : cnt_q;
  end

  assign push_o = fire && last_i;
  assign sums_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (fire) begin
      if (last_i) begin
        acc_q <= '0;
        cnt_q <= '0;
      end else begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxLayers)) else $error("layer count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> cnt_q == '0) else $error("count not cleared after texel");

endmodule

[hw/rtl/wmlb_queue.sv]
// Two-entry queue of texel sums between front end and back end.
module wmlb_queue import wmlb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  texel_sums_t data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        pop_i,
  output texel_sums_t data_o
);

  texel_sums_t mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");

endmodule

[hw/rtl/wmlb_back.sv]
// Back end: divides sums by total weight and normalizes the normal, one texel at a time.
module wmlb_back import wmlb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        pop_o,
  input  texel_sums_t sums_i,
  output logic        valid_o,
  input  logic        ready_i,
  output texel_out_t  texel_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StNorm = 3'd4;
  localparam logic [2:0] StEnc  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  localparam int unsigned QW  = 40;  // Q is a sum of three squared 18-bit magnitudes, plus margin
  localparam int unsigned RW  = 56;  // Q << 16
  localparam int unsigned LW  = 28;  // sqrt result
  localparam int unsigned NW  = 43;  // |s| << 24
  localparam int unsigned QQW = 17;

  logic [2:0]       st_q;
  logic [5:0]       it_q;
  logic [1:0]       ci_q;
  texel_sums_t      s_q;
  texel_out_t       o_q;
  logic [SumW-1:0]  num_q [6];
  logic [SumW-1:0]  rem_q [6];
  logic [QW-1:0]    qsum_q;
  logic [RW-1:0]    sv_q;
  logic [LW:0]      sr_q;
  logic [RW+1:0]    srem_q;
  logic [NW-1:0]    nn_q;
  logic [LW+1:0]    nrem_q;
  logic [NW-1:0]    quo_q;
  logic [QQW-1:0]   qc_q [3];
  logic [1:0]       sqc_q;

  logic signed [NSumW-1:0] comp;
  logic [NSumW-1:0]        mag;
  logic [2*NSumW-1:0]      sq;
  logic [RW+1:0]           trial;
  logic [LW+1:0]           ntrial;

  assign pop_o   = (st_q == StIdle) && valid_i;
  assign valid_o = st_q == StOut;
  assign texel_o = o_q;

  always_comb begin
    unique case (ci_q)
      2'd0:    comp = s_q.nrm_x;
      2'd1:    comp = s_q.nrm_y;
      default: comp = s_q.nrm_z;
    endcase
    mag    = comp[NSumW-1] ? NSumW'(-comp) : NSumW'(comp);
    sq     = mag * mag;
    trial  = {srem_q[RW-1:0], sv_q[RW-1 -: 2]} - {sr_q, 2'b01};
    ntrial = {nrem_q[LW:0], nn_q[NW-1]} - {1'b0, sr_q};
  end

  function automatic logic [7:0] enc(input logic neg, input logic [QQW-1:0] q);
    logic [QQW:0] u;
    logic [QQW+8:0] p;
    begin
      u = neg ? (18'd65536 - {1'b0, q}) : (18'd65536 + {1'b0, q});
      p = u * 9'd255;
      enc = (p[QQW+8:17] > 10'd255) ? 8'd255 : p[24:17];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (valid_i) begin
        s_q      <= sums_i;
        num_q[0] <= sums_i.alb_r; num_q[1] <= sums_i.alb_g;
        num_q[2] <= sums_i.alb_b; num_q[3] <= sums_i.mat_o;
        num_q[4] <= sums_i.mat_r; num_q[5] <= sums_i.mat_m;
        for (int k = 0; k < 6; k++) rem_q[k] <= '0;
        it_q     <= '0;
      end
      StDiv: begin
        // One restoring division bit per cycle, six lanes side by side.
        for (int k = 0; k < 6; k++) begin
          if ({rem_q[k][SumW-2:0], num_q[k][SumW-1]} >= SumW'(s_q.wtot)) begin
            rem_q[k] <= {rem_q[k][SumW-2:0], num_q[k][SumW-1]} - SumW'(s_q.wtot);
            num_q[k] <= {num_q[k][SumW-2:0], 1'b1};
          end else begin
            rem_q[k] <= {rem_q[k][SumW-2:0], num_q[k][SumW-1]};
            num_q[k] <= {num_q[k][SumW-2:0], 1'b0};
          end
        end
        it_q <= it_q + 1'b1;
        if (it_q == 6'(SumW - 1)) begin
          ci_q <= 2'd0; qsum_q <= '0; sqc_q <= 2'd0;
        end
      end
      StSq: begin
        qsum_q <= qsum_q + QW'(sq);
        ci_q   <= ci_q + 1'b1;
        sqc_q  <= sqc_q + 1'b1;
        if (sqc_q == 2'd2) begin
          sv_q <= {qsum_q + QW'(sq), 16'd0};
          sr_q <= '0; srem_q <= '0; it_q <= '0;
        end
      end
      StSqrt: begin
        // Two radicand bits per cycle.
        sv_q <= {sv_q[RW-3:0], 2'b00};
        if (!trial[RW+1]) begin
          srem_q <= trial; sr_q <= {sr_q[LW-1:0], 1'b1};
        end else begin
          srem_q <= {srem_q[RW-1:0], sv_q[RW-1 -: 2]}; sr_q <= {sr_q[LW-1:0], 1'b0};
        end
        if (it_q == 6'(RW/2 - 1)) begin
          ci_q <= 2'd0;
          it_q <= '0;
        end else begin
          it_q <= it_q + 1'b1;
        end
      end
      StNorm: begin
        if (it_q == '0) begin
          nn_q <= {mag, 24'd0}; nrem_q <= '0; quo_q <= '0;
          it_q <= 6'd1;
        end else begin
          nn_q <= {nn_q[NW-2:0], 1'b0};
          if (!ntrial[LW+1]) begin
            nrem_q <= ntrial; quo_q <= {quo_q[NW-2:0], 1'b1};
          end else begin
            nrem_q <= {nrem_q[LW:0], nn_q[NW-1]}; quo_q <= {quo_q[NW-2:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
        end
      end
      StEnc: begin
        qc_q[ci_q] <= (quo_q > NW'(65536)) ? QQW'(65536) : quo_q[QQW-1:0];
        ci_q <= ci_q + 1'b1;
        it_q <= '0;
        if (ci_q == 2'd2) begin
          if (s_q.wtot == '0) begin
            o_q <= '{8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd255,
                     8'd255, 8'd127, 8'd0};
          end else begin
            o_q.alb_r <= num_q[0][7:0]; o_q.alb_g <= num_q[1][7:0];
            o_q.alb_b <= num_q[2][7:0]; o_q.occ <= num_q[3][7:0];
            o_q.rgh <= num_q[4][7:0];   o_q.met <= num_q[5][7:0];
            if (qsum_q == '0) begin
              o_q.nrm_x <= 8'd127; o_q.nrm_y <= 8'd127; o_q.nrm_z <= 8'd255;
            end else begin
              o_q.nrm_x <= enc(s_q.nrm_x[NSumW-1], qc_q[0]);
              o_q.nrm_y <= enc(s_q.nrm_y[NSumW-1], qc_q[1]);
              o_q.nrm_z <= enc(s_q.nrm_z[NSumW-1],
                               (quo_q > NW'(65536)) ? QQW'(65536) : quo_q[QQW-1:0]);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: if (valid_i) st_q <= StDiv;
        StDiv:  if (it_q == 6'(SumW - 1)) st_q <= StSq;
        StSq:   if (sqc_q == 2'd2) st_q <= StSqrt;
        StSqrt: if (it_q == 6'(RW/2 - 1)) st_q <= (sr_q == '0 && !(!trial[RW+1]))
                                                   ? StEnc : StNorm;
        StNorm: if (it_q == 6'(NW)) st_q <= StEnc;
        StEnc:  st_q <= (ci_q == 2'd2) ? StOut : StNorm;
        StOut:  if (ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> st_q == StDiv) else $error("pop without start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> $stable(o_q)) else $error("result changed");

endmodule
